### rtl/core/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants of the LRU replacement selector with chances.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int unsigned WAYS        = 8;
  localparam int unsigned SETS        = 64;
  localparam int unsigned STAMP_BITS  = 32;
  localparam int unsigned CHANCE_BITS = 4;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned WAY_W       = $clog2(WAYS);
  localparam int unsigned SET_W       = $clog2(SETS);
  localparam int unsigned ENTRIES     = SETS * WAYS;
  localparam int unsigned ADDR_W      = $clog2(ENTRIES);

  typedef enum logic [OP_W-1:0] {
    OP_INVAL  = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_INSERT = 2'd2,
    OP_VICTIM = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_RESTAMP
  } state_e;

  typedef struct packed {
    logic [STAMP_BITS-1:0]  stamp;
    logic [CHANCE_BITS-1:0] chance;
  } entry_t;

  typedef struct packed {
    logic             cmp;
    logic             load;
    logic             restamp;
    logic [WAY_W-1:0] way;
  } scan_ctl_t;

endpackage

### rtl/core/lrc_ram.sv
// ----------------------------------------------------------------------------
// lrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lrc_minu.sv
// ----------------------------------------------------------------------------
// lrc_minu
// Shared minimum unit: one stamp compare per beat, holds the running oldest.
// ----------------------------------------------------------------------------
module lrc_minu (
  input  logic                            clk_i,
  input  lrc_pkg::scan_ctl_t              ctl_i,
  input  lrc_pkg::entry_t                 rdata_i,
  input  logic [lrc_pkg::STAMP_BITS-1:0]  now_i,
  output logic [lrc_pkg::WAY_W-1:0]       best_way_o,
  output logic [lrc_pkg::CHANCE_BITS-1:0] best_chance_o
);
  import lrc_pkg::*;

  logic [WAY_W-1:0]       best_way_q;
  logic [STAMP_BITS-1:0]  best_stamp_q;
  logic [CHANCE_BITS-1:0] best_chance_q;
  logic                   older;

  assign older = rdata_i.stamp < best_stamp_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.restamp) begin
      // candidate was re-stamped and lost a chance; it seeds the next pass
      best_stamp_q  <= now_i;
      best_chance_q <= best_chance_q - CHANCE_BITS'(1);
    end else if (ctl_i.cmp && (ctl_i.load || older)) begin
      best_way_q    <= ctl_i.way;
      best_stamp_q  <= rdata_i.stamp;
      best_chance_q <= rdata_i.chance;
    end
  end

  assign best_way_o    = best_way_q;
  assign best_chance_o = best_chance_q;

endmodule

### rtl/core/lrc_seq.sv
// ----------------------------------------------------------------------------
// lrc_seq
// Sequencer: clearing pass, way updates and repeated victim scans.
// ----------------------------------------------------------------------------
module lrc_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lrc_pkg::OP_W-1:0]        opcode_i,
  input  logic [lrc_pkg::SET_W-1:0]       set_index_i,
  input  logic [lrc_pkg::WAY_W-1:0]       way_i,
  input  logic [lrc_pkg::STAMP_BITS-1:0]  now_i,
  input  logic [lrc_pkg::CHANCE_BITS-1:0] scale_i,
  output logic                            ram_we_o,
  output logic [lrc_pkg::ADDR_W-1:0]      ram_waddr_o,
  output lrc_pkg::entry_t                 ram_wdata_o,
  output logic                            ram_re_o,
  output logic [lrc_pkg::ADDR_W-1:0]      ram_raddr_o,
  input  lrc_pkg::entry_t                 ram_rdata_i,
  output lrc_pkg::scan_ctl_t              scan_ctl_o,
  output logic [lrc_pkg::STAMP_BITS-1:0]  now_o,
  input  logic [lrc_pkg::WAY_W-1:0]       best_way_i,
  input  logic [lrc_pkg::CHANCE_BITS-1:0] best_chance_i,
  output logic                            victim_valid_o,
  output logic [lrc_pkg::WAY_W-1:0]       victim_way_o
);
  import lrc_pkg::*;

  state_e                state_q, state_d;
  logic [ADDR_W-1:0]     clr_q, clr_d;
  logic [WAY_W-1:0]      scan_q, scan_d;
  logic                  first_q, first_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [WAY_W-1:0]      rd_way_q, rd_way_d;
  op_e                   op_q;
  logic [ADDR_W-1:0]     base_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [STAMP_BITS-1:0] now_q;
  logic                  accept;
  logic                  way_ok;

  assign accept = start_i && (state_q == ST_IDLE);
  assign way_ok = (WAY_W + 1)'(way_i) < (WAY_W + 1)'(WAYS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      scan_q   <= '0;
      first_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_way_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      scan_q   <= scan_d;
      first_q  <= first_d;
      rd_vld_q <= rd_vld_d;
      rd_way_q <= rd_way_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(opcode_i);
      base_q <= ADDR_W'(set_index_i) * ADDR_W'(WAYS);
      addr_q <= ADDR_W'(set_index_i) * ADDR_W'(WAYS) + ADDR_W'(way_i);
      now_q  <= now_i;
    end
  end

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    scan_d         = scan_q;
    first_d        = first_q;
    rd_vld_d       = 1'b0;
    rd_way_d       = scan_q;
    ram_we_o       = 1'b0;
    ram_waddr_o    = addr_q;
    ram_wdata_o    = '0;
    ram_re_o       = 1'b0;
    ram_raddr_o    = addr_q;
    victim_valid_o = 1'b0;
    scan_ctl_o     = '{cmp: rd_vld_q, load: first_q && (rd_way_q == '0),
                       restamp: 1'b0, way: rd_way_q};

    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (op_e'(opcode_i) == OP_VICTIM) begin
            state_d = ST_SCAN;
            scan_d  = '0;
            first_d = 1'b1;
          end else if (way_ok) begin
            state_d = ST_UPD_RD;
          end
        end
      end
      ST_UPD_RD: begin
        ram_re_o = 1'b1;
        state_d  = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        ram_we_o = 1'b1;
        case (op_q)
          OP_INVAL:  ram_wdata_o = '0;
          OP_TOUCH:  ram_wdata_o = '{stamp: now_q, chance: ram_rdata_i.chance};
          OP_INSERT: ram_wdata_o = '{stamp: now_q, chance: scale_i};
          default:   ram_wdata_o = ram_rdata_i;
        endcase
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = base_q + ADDR_W'(scan_q);
        rd_vld_d    = 1'b1;
        scan_d      = scan_q + WAY_W'(1);
        if (scan_q == WAY_W'(WAYS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (best_chance_i == '0) begin
          victim_valid_o = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_RESTAMP;
        end
      end
      ST_RESTAMP: begin
        ram_we_o           = 1'b1;
        ram_waddr_o        = base_q + ADDR_W'(best_way_i);
        ram_wdata_o        = '{stamp: now_q, chance: best_chance_i - CHANCE_BITS'(1)};
        scan_ctl_o.restamp = 1'b1;
        first_d            = 1'b0;
        scan_d             = '0;
        state_d            = ST_SCAN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o       = state_q != ST_IDLE;
  assign now_o        = now_q;
  assign victim_way_o = best_way_i;

endmodule

### rtl/core/lru_replacement_with_chances.sv
// ----------------------------------------------------------------------------
// lru_replacement_with_chances
// LRU replacement selector with per-way second-chance counters.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  command  | in        | start_i / busy_o     | opcode_i set_index_i way_i now_i
//  result   | out       | victim_valid_o       | victim_way_o
//  config   | in        | cfg_valid_i/ready_o  | cfg_data_i (scale factor)
//
//  Invalidate, touch and insert: accept, read, write back. Victim search: scan,
//  drain and decide, with re-stamp and rescan while the oldest way has a
//  chance; one stamp compare per cycle in the shared minimum unit, one RAM read
//  per way on a single port. After reset all SETS*WAYS entries are cleared with
//  busy_o high. The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module lru_replacement_with_chances (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lrc_pkg::OP_W-1:0]        opcode_i,
  input  logic [lrc_pkg::SET_W-1:0]       set_index_i,
  input  logic [lrc_pkg::WAY_W-1:0]       way_i,
  input  logic [lrc_pkg::STAMP_BITS-1:0]  now_i,
  output logic                            victim_valid_o,
  output logic [lrc_pkg::WAY_W-1:0]       victim_way_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lrc_pkg::CHANCE_BITS-1:0] cfg_data_i
);
  import lrc_pkg::*;

  logic [CHANCE_BITS-1:0] scale_q;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  entry_t                 ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  entry_t                 ram_rdata;
  scan_ctl_t              scan_ctl;
  logic [STAMP_BITS-1:0]  now_q;
  logic [WAY_W-1:0]       best_way;
  logic [CHANCE_BITS-1:0] best_chance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  lrc_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .set_index_i    (set_index_i),
    .way_i          (way_i),
    .now_i          (now_i),
    .scale_i        (scale_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .scan_ctl_o     (scan_ctl),
    .now_o          (now_q),
    .best_way_i     (best_way),
    .best_chance_i  (best_chance),
    .victim_valid_o (victim_valid_o),
    .victim_way_o   (victim_way_o)
  );

  lrc_minu u_minu (
    .clk_i         (clk_i),
    .ctl_i         (scan_ctl),
    .rdata_i       (ram_rdata),
    .now_i         (now_q),
    .best_way_o    (best_way),
    .best_chance_o (best_chance)
  );

  lrc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted command");

  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    victim_valid_o |=> !busy_o)
    else $error("not idle after result beat");

  a_result_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    victim_valid_o |-> (busy_o && !scan_ctl.restamp && !ram_we))
    else $error("result beat while updating storage");

endmodule

### verif/lru_replacement_with_chances_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_replacement_with_chances_test
// Self-checking bench for the LRU replacement selector with chance counters.
// A directed table covers reset state, extreme stamps, ties, invalidation,
// chance consumption and time going backwards. Random phases then run under
// several scale factors, with commands aimed at a few hot sets. Every
// victim beat is checked against the row's expected way where a directed row
// gives one, else against a cycle-free model of the stamp and chance arrays.
// ----------------------------------------------------------------------------
module lru_replacement_with_chances_test;
  import lrc_pkg::*;

  typedef enum bit {
    ROW_CMD,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    op_e                    op;
    logic [SET_W-1:0]       set_sel;
    logic [WAY_W-1:0]       way;
    logic [STAMP_BITS-1:0]  now;
    logic [CHANCE_BITS-1:0] scale;
    bit                     known;
    logic [WAY_W-1:0]       victim;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 8;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [OP_W-1:0]        opcode_i;
  logic [SET_W-1:0]       set_index_i;
  logic [WAY_W-1:0]       way_i;
  logic [STAMP_BITS-1:0]  now_i;
  logic                   victim_valid_o;
  logic [WAY_W-1:0]       victim_way_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CHANCE_BITS-1:0] cfg_data_i;

  logic [STAMP_BITS-1:0]  way_stamp [ENTRIES];
  logic [CHANCE_BITS-1:0] way_chances [ENTRIES];
  logic [CHANCE_BITS-1:0] scale_reg;
  logic [WAY_W-1:0]       pending_victims [$];
  int                     fail_count;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_CFG, OP_INVAL,  6'd0,  3'd0, 32'd0,          4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd0,  3'd0, 32'd0,          4'd0,  1'b1, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd63, 3'd7, 32'hFFFF_FFFF,  4'd0,  1'b1, 3'd0},
    '{ROW_CMD, OP_TOUCH,  6'd5,  3'd0, 32'd100,        4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd5,  3'd0, 32'd100,        4'd0,  1'b1, 3'd1},
    '{ROW_CMD, OP_INSERT, 6'd5,  3'd1, 32'd200,        4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd5,  3'd5, 32'd200,        4'd0,  1'b1, 3'd2},
    '{ROW_CMD, OP_TOUCH,  6'd63, 3'd7, 32'hFFFF_FFFF,  4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd63, 3'd7, 32'hFFFF_FFFF,  4'd0,  1'b1, 3'd0},
    '{ROW_CMD, OP_INVAL,  6'd5,  3'd0, 32'd0,          4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd5,  3'd0, 32'd300,        4'd0,  1'b1, 3'd0},
    '{ROW_CFG, OP_INVAL,  6'd0,  3'd0, 32'd0,          4'd15, 1'b0, 3'd0},
    // inserted way 0 ties the untouched ways, so it burns a chance first
    '{ROW_CMD, OP_INSERT, 6'd9,  3'd0, 32'd0,          4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd9,  3'd0, 32'd7,          4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd9,  3'd0, 32'd8,          4'd0,  1'b0, 3'd0},
    // time going backwards
    '{ROW_CMD, OP_TOUCH,  6'd9,  3'd1, 32'd3,          4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd9,  3'd0, 32'd2,          4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_INSERT, 6'd9,  3'd7, 32'hFFFF_FFFF,  4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_INVAL,  6'd9,  3'd0, 32'hFFFF_FFFF,  4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd9,  3'd0, 32'd10,         4'd0,  1'b0, 3'd0},
    '{ROW_CFG, OP_INVAL,  6'd0,  3'd0, 32'd0,          4'd1,  1'b0, 3'd0},
    '{ROW_CMD, OP_INSERT, 6'd40, 3'd2, 32'd12,         4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd40, 3'd0, 32'd12,         4'd0,  1'b0, 3'd0},
    '{ROW_CMD, OP_VICTIM, 6'd63, 3'd0, 32'hFFFF_FFFF,  4'd0,  1'b0, 3'd0}
  };

  lru_replacement_with_chances dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .set_index_i    (set_index_i),
    .way_i          (way_i),
    .now_i          (now_i),
    .victim_valid_o (victim_valid_o),
    .victim_way_o   (victim_way_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Updates the stamp and chance arrays; returns the victim for a search.
  function automatic logic [WAY_W-1:0] apply_command(input op_e op,
                                                     input logic [SET_W-1:0] set_sel,
                                                     input logic [WAY_W-1:0] way,
                                                     input logic [STAMP_BITS-1:0] now);
    int               base;
    logic [WAY_W-1:0] cand;
    logic [WAY_W-1:0] best;
    base = int'(set_sel) * WAYS;
    cand = '0;
    case (op)
      OP_INVAL: begin
        way_stamp[base + way]   = '0;
        way_chances[base + way] = '0;
      end
      OP_TOUCH: begin
        way_stamp[base + way] = now;
      end
      OP_INSERT: begin
        way_stamp[base + way]   = now;
        way_chances[base + way] = scale_reg;
      end
      default: begin
        while (1) begin
          best = cand;
          for (int i = 0; i < WAYS; i++) begin
            if (way_stamp[base + i] < way_stamp[base + best]) best = WAY_W'(i);
          end
          cand = best;
          if (way_chances[base + cand] == '0) break;
          way_stamp[base + cand]   = now;
          way_chances[base + cand] = way_chances[base + cand] - 1'b1;
        end
      end
    endcase
    return cand;
  endfunction

  task automatic issue(input op_e op, input logic [SET_W-1:0] set_sel,
                       input logic [WAY_W-1:0] way, input logic [STAMP_BITS-1:0] now,
                       input bit known, input logic [WAY_W-1:0] victim);
    logic [WAY_W-1:0] predicted;
    @(negedge clk_i);
    start_i     <= 1'b1;
    opcode_i    <= op;
    set_index_i <= set_sel;
    way_i       <= way;
    now_i       <= now;
    do @(posedge clk_i); while (busy_o);
    predicted = apply_command(op, set_sel, way, now);
    if (op == OP_VICTIM) pending_victims.push_back(known ? victim : predicted);
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i     <= 1'b0;
      opcode_i    <= OP_W'($urandom);
      set_index_i <= SET_W'($urandom);
      way_i       <= WAY_W'($urandom);
      now_i       <= $urandom;
    end
  endtask

  task automatic settle();
    idle_sender(1);
    while (pending_victims.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [CHANCE_BITS-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    scale_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= CHANCE_BITS'($urandom);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && victim_valid_o === 1'b1) begin
      if (pending_victims.size() == 0) begin
        $error("victim_way: no beat expected, actual %0d", victim_way_o);
        fail_count++;
      end else begin
        logic [WAY_W-1:0] exp_way;
        exp_way = pending_victims.pop_front();
        if (victim_way_o !== exp_way) begin
          $error("victim_way: expected %0d, actual %0d", exp_way, victim_way_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [STAMP_BITS-1:0]  clock_now;
    logic [SET_W-1:0]       hot_sets [4];
    logic [CHANCE_BITS-1:0] phase_scale [PHASES];
    logic [SET_W-1:0]       set_sel;
    op_e                    op;
    int                     burst_left;
    int                     pick;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    opcode_i    = '0;
    set_index_i = '0;
    way_i       = '0;
    now_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    fail_count  = 0;
    scale_reg   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      way_stamp[i]   = '0;
      way_chances[i] = '0;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_scale(directed_rows[i].scale);
      end else begin
        issue(directed_rows[i].op, directed_rows[i].set_sel, directed_rows[i].way,
              directed_rows[i].now, directed_rows[i].known, directed_rows[i].victim);
      end
    end

    hot_sets[0]    = '0;
    hot_sets[1]    = '1;
    hot_sets[2]    = SET_W'($urandom);
    hot_sets[3]    = SET_W'($urandom);
    phase_scale[0] = CHANCE_BITS'($urandom_range(1, 14));
    phase_scale[1] = '1;
    phase_scale[2] = '0;
    phase_scale[3] = CHANCE_BITS'($urandom);
    phase_scale[4] = CHANCE_BITS'($urandom_range(2, 6));
    clock_now      = $urandom;
    burst_left     = 0;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_scale(phase_scale[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (pick < 10)      op = OP_INVAL;
        else if (pick < 40) op = OP_TOUCH;
        else if (pick < 70) op = OP_INSERT;
        else                op = OP_VICTIM;
        set_sel = ($urandom_range(0, 3) != 0) ? hot_sets[$urandom_range(0, 3)]
                                                : SET_W'($urandom);
        // mostly small steps so stamps tie; rare jumps, some backwards
        if ($urandom_range(0, 99) < 3) clock_now = $urandom;
        else                           clock_now = clock_now + $urandom_range(0, 3);
        issue(op, set_sel, WAY_W'($urandom), clock_now, 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_victims.size() == 0) begin
      $display("lru_replacement_with_chances_test passed");
    end else begin
      $display("lru_replacement_with_chances_test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("lru_replacement_with_chances_test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/lrc_pkg.sv
rtl/core/lrc_ram.sv
rtl/core/lrc_minu.sv
rtl/core/lrc_seq.sv
rtl/core/lru_replacement_with_chances.sv
verif/lru_replacement_with_chances_test.sv
